// ===== rtl/core/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg
// Types and constants shared by the changed span finder and its parts.
// ----------------------------------------------------------------------------
package csf_pkg;

    localparam int MAX_DIM_BITS  = 12;
    localparam int CHANNEL_BITS  = 8;
    localparam int CFG_DIM_BITS  = MAX_DIM_BITS + 1;
    localparam int LIMIT_BITS    = 9;
    localparam int RUN_BITS      = 8;
    localparam int CFG_DATA_BITS = CFG_DIM_BITS;
    localparam int CFG_ADDR_BITS = 2;

    localparam int SUM_BITS    = 2 * CHANNEL_BITS + 2;
    localparam int LIM_SQ_BITS = 2 * (LIMIT_BITS + 1);
    localparam int CMP_BITS    = (SUM_BITS > LIM_SQ_BITS) ? SUM_BITS : LIM_SQ_BITS;

    localparam logic [CFG_DIM_BITS-1:0] DIM_MAX = CFG_DIM_BITS'(1) << MAX_DIM_BITS;

    localparam logic [CFG_DIM_BITS-1:0] WIDTH_RESET  = CFG_DIM_BITS'(1024);
    localparam logic [CFG_DIM_BITS-1:0] HEIGHT_RESET = CFG_DIM_BITS'(768);
    localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET  = LIMIT_BITS'(16);
    localparam logic [RUN_BITS-1:0]     RUN_RESET    = RUN_BITS'(32);
    localparam logic [LIM_SQ_BITS-1:0]  LIM_SQ_RESET =
        LIM_SQ_BITS'((int'(LIMIT_RESET) + 1) * (int'(LIMIT_RESET) + 1));

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FRAME_WIDTH          = 2'd0,
        REG_FRAME_HEIGHT         = 2'd1,
        REG_COLOR_DISTANCE_LIMIT = 2'd2,
        REG_CLOSE_RUN_LENGTH     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] old_red;
        logic [CHANNEL_BITS-1:0] old_green;
        logic [CHANNEL_BITS-1:0] old_blue;
        logic [CHANNEL_BITS-1:0] new_red;
        logic [CHANNEL_BITS-1:0] new_green;
        logic [CHANNEL_BITS-1:0] new_blue;
        logic                    frame_start;
    } pixel_pair_t;

    typedef struct packed {
        logic [MAX_DIM_BITS-1:0] span_left;
        logic [MAX_DIM_BITS-1:0] span_right;
        logic [MAX_DIM_BITS-1:0] span_row;
    } span_t;

    typedef struct packed {
        logic [CFG_DIM_BITS-1:0] width;
        logic [CFG_DIM_BITS-1:0] height;
        logic [RUN_BITS-1:0]     run_len;
    } track_cfg_t;

endpackage

// ===== rtl/core/csf_pixel_compare.sv =====
// ----------------------------------------------------------------------------
// csf_pixel_compare
// Flags a pixel pair as changed when its squared RGB distance reaches the
// squared limit.
// ----------------------------------------------------------------------------
module csf_pixel_compare (
    input  csf_pkg::pixel_pair_t                 pixel,
    input  logic [csf_pkg::LIM_SQ_BITS-1:0]      lim_sq,
    output logic                                 changed
);

    localparam int SQ_BITS = 2 * csf_pkg::CHANNEL_BITS;

    logic [csf_pkg::CHANNEL_BITS-1:0]   diff_r, diff_g, diff_b;
    logic [SQ_BITS-1:0]                 sq_r, sq_g, sq_b;
    logic [csf_pkg::SUM_BITS-1:0]       sum;

    always_comb begin
        diff_r = (pixel.old_red > pixel.new_red) ? pixel.old_red - pixel.new_red
                                                 : pixel.new_red - pixel.old_red;
        diff_g = (pixel.old_green > pixel.new_green) ? pixel.old_green - pixel.new_green
                                                     : pixel.new_green - pixel.old_green;
        diff_b = (pixel.old_blue > pixel.new_blue) ? pixel.old_blue - pixel.new_blue
                                                   : pixel.new_blue - pixel.old_blue;
        sq_r = SQ_BITS'(diff_r) * SQ_BITS'(diff_r);
        sq_g = SQ_BITS'(diff_g) * SQ_BITS'(diff_g);
        sq_b = SQ_BITS'(diff_b) * SQ_BITS'(diff_b);
        sum  = csf_pkg::SUM_BITS'(sq_r) + csf_pkg::SUM_BITS'(sq_g)
             + csf_pkg::SUM_BITS'(sq_b);
        changed = csf_pkg::CMP_BITS'(sum) >= csf_pkg::CMP_BITS'(lim_sq);
    end

endmodule

// ===== rtl/core/csf_span_tracker.sv =====
// ----------------------------------------------------------------------------
// csf_span_tracker
// Keeps the raster position and the open span, and holds the closed span in
// the output register until the word is taken.
// ----------------------------------------------------------------------------
module csf_span_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csf_pkg::track_cfg_t  cfg,
    input  logic                 advance,
    input  logic                 changed,
    input  logic                 frame_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output csf_pkg::span_t       m_span
);

    localparam int DB = csf_pkg::MAX_DIM_BITS;
    localparam int CB = csf_pkg::CFG_DIM_BITS;
    localparam int RB = csf_pkg::RUN_BITS;

    logic          open_reg, open_next;
    logic [RB-1:0] run_reg, run_next;
    logic [DB-1:0] start_reg, start_next;
    logic [DB-1:0] col_reg, col_next;
    logic [DB-1:0] row_reg, row_next;
    logic          m_valid_reg, m_valid_next;
    csf_pkg::span_t span_reg, span_next;

    logic          open_c;
    logic [RB-1:0] run_c;
    logic [DB-1:0] col, row;
    logic          emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            run_reg     <= '0;
            start_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            open_reg    <= open_next;
            run_reg     <= run_next;
            start_reg   <= start_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
        span_reg <= span_next;
    end

    always_comb begin
        open_c = frame_start ? 1'b0 : open_reg;
        run_c  = frame_start ? '0 : run_reg;
        col    = frame_start ? '0 : col_reg;
        row    = frame_start ? '0 : row_reg;

        open_next  = open_c;
        run_next   = run_c;
        start_next = start_reg;
        emit       = 1'b0;
        span_next  = span_reg;
        span_next.span_row = row;

        if (open_c) begin
            if (!changed) begin
                run_next = run_c + RB'(1);
                if (run_next >= cfg.run_len) begin
                    open_next            = 1'b0;
                    emit                 = 1'b1;
                    span_next.span_right = col - DB'(cfg.run_len) + DB'(1);
                end
            end else begin
                run_next = '0;
            end
        end else if (changed) begin
            open_next  = 1'b1;
            run_next   = '0;
            start_next = col;
        end

        span_next.span_left = start_next;

        if ((CB'(col) + CB'(1)) >= cfg.width) begin
            if (open_next) begin
                emit                 = 1'b1;
                span_next.span_right = DB'(cfg.width - CB'(1));
            end
            open_next = 1'b0;
            run_next  = '0;
            col_next  = '0;
            row_next  = ((CB'(row) + CB'(1)) >= cfg.height) ? '0 : row + DB'(1);
        end else begin
            col_next = col + DB'(1);
            row_next = row;
        end

        if (!advance) begin
            open_next  = open_reg;
            run_next   = run_reg;
            start_next = start_reg;
            col_next   = col_reg;
            row_next   = row_reg;
            span_next  = span_reg;
            m_valid_next = m_valid_reg && !m_ready;
        end else begin
            if (!emit) begin
                span_next = span_reg;
            end
            m_valid_next = emit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_span  = span_reg;

endmodule

// ===== rtl/core/changed_span_finder_unit.sv =====
// ----------------------------------------------------------------------------
// changed_span_finder_unit
// Pipeline: the input pixel register, then the tracker's span output register.
// Throughput: one pixel word per cycle (single update stage) unless m_ready stalls.
// Reset: synchronous, active low; config registers return to defaults, no span open.
// ----------------------------------------------------------------------------
module changed_span_finder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [csf_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [csf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  csf_pkg::pixel_pair_t                s_pixel,
    output logic                                m_valid,
    input  logic                                m_ready,
    output csf_pkg::span_t                      m_span
);

    logic [csf_pkg::CFG_DIM_BITS-1:0] width_reg, height_reg;
    logic [csf_pkg::RUN_BITS-1:0]     run_len_reg;
    logic [csf_pkg::LIM_SQ_BITS-1:0]  lim_sq_reg;
    logic [csf_pkg::LIMIT_BITS:0]     lim1;

    logic                  p_valid_reg;
    csf_pkg::pixel_pair_t  pixel_reg;
    logic                  advance;
    logic                  changed;
    csf_pkg::track_cfg_t   track_cfg;

    assign lim1 = {1'b0, cfg_wdata[csf_pkg::LIMIT_BITS-1:0]} + (csf_pkg::LIMIT_BITS+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= csf_pkg::WIDTH_RESET;
            height_reg  <= csf_pkg::HEIGHT_RESET;
            run_len_reg <= csf_pkg::RUN_RESET;
            lim_sq_reg  <= csf_pkg::LIM_SQ_RESET;
        end else if (cfg_we) begin
            unique case (csf_pkg::cfg_reg_t'(cfg_addr))
                csf_pkg::REG_FRAME_WIDTH: begin
                    width_reg <= cfg_wdata;
                end
                csf_pkg::REG_FRAME_HEIGHT: begin
                    height_reg <= cfg_wdata;
                end
                csf_pkg::REG_COLOR_DISTANCE_LIMIT: begin
                    lim_sq_reg <= csf_pkg::LIM_SQ_BITS'(lim1) * csf_pkg::LIM_SQ_BITS'(lim1);
                end
                csf_pkg::REG_CLOSE_RUN_LENGTH: begin
                    run_len_reg <= cfg_wdata[csf_pkg::RUN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        track_cfg.width = (width_reg == '0) ? csf_pkg::CFG_DIM_BITS'(1)
                        : (width_reg > csf_pkg::DIM_MAX) ? csf_pkg::DIM_MAX : width_reg;
        track_cfg.height = (height_reg == '0) ? csf_pkg::CFG_DIM_BITS'(1)
                         : (height_reg > csf_pkg::DIM_MAX) ? csf_pkg::DIM_MAX : height_reg;
        track_cfg.run_len = (run_len_reg == '0) ? csf_pkg::RUN_BITS'(1) : run_len_reg;
    end

    assign advance = p_valid_reg && (!m_valid || m_ready);
    assign s_ready = !p_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            pixel_reg <= s_pixel;
        end
    end

    csf_pixel_compare u_compare (
        .pixel   (pixel_reg),
        .lim_sq  (lim_sq_reg),
        .changed (changed)
    );

    csf_span_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (track_cfg),
        .advance     (advance),
        .changed     (changed),
        .frame_start (pixel_reg.frame_start),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_span      (m_span)
    );

endmodule
